### design/ird_pkg.sv
// Shared types and constants for the impulse response deconvolution block.
// No dependencies; used by every module under design/ except ird_front.
package ird_pkg;

	localparam int RESP_W      = 32;  // response sample width
	localparam int ACC_W       = 64;  // product accumulator and numerator width
	localparam int INDEX_W     = 8;   // sample_index field width
	localparam int QUEUE_DEPTH = 2;   // entries between front and back

	// back-end sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_DIFF,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_QUOT,
		ST_DONE
	} back_state_t;

	// per-result status, saturated in the low bit
	typedef struct packed {
		logic divide_error;
		logic saturated;
	} result_flags_t;

	// divider result back to the sequencer
	typedef struct packed {
		logic             done;
		logic [ACC_W-1:0] quotient;
	} div_result_t;

endpackage

### design/ird_front.sv
// Input side: accepts sample pairs and assigns each its position in the record.
// Does not use ird_pkg; its item layout is shared with ird_back.
module ird_front #(
	parameter int DEPTH        = 256,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]       s_tdata,
	input  logic                                      s_tuser,
	output logic                                      push_valid,
	input  logic                                      push_ready,
	output logic [2*SAMPLE_WIDTH+$clog2(DEPTH)-1:0]   push_data
);

	localparam int ADDR_W = $clog2(DEPTH);
	localparam int POS_W  = $clog2(DEPTH + 1);

	logic [POS_W-1:0]  pos_q;
	logic [ADDR_W-1:0] k_c;
	logic              accept;

	assign s_tready   = push_ready;
	assign push_valid = s_tvalid;
	assign accept     = s_tvalid & push_ready;

	// restart the record on a start mark or once the stores are full
	always_comb begin
		if (s_tuser || (pos_q >= POS_W'(DEPTH))) begin
			k_c = '0;
		end else begin
			k_c = pos_q[ADDR_W-1:0];
		end
	end

	assign push_data = {k_c, s_tdata[2*SAMPLE_WIDTH-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			pos_q <= POS_W'(k_c) + POS_W'(1);
		end
	end

endmodule

### design/ird_queue.sv
// Short FIFO between the front and the back of the deconvolution block.
// Uses ird_pkg::QUEUE_DEPTH.
module ird_queue #(
	parameter int WIDTH = 40
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);

	localparam int PTR_W = (ird_pkg::QUEUE_DEPTH > 1) ? $clog2(ird_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(ird_pkg::QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] entry_q [ird_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign wr_ready = (count_q != CNT_W'(ird_pkg::QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = entry_q[rd_ptr_q];
	assign do_wr    = wr_valid & wr_ready;
	assign do_rd    = rd_valid & rd_ready;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(ird_pkg::QUEUE_DEPTH - 1)) ? '0 :
					wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(ird_pkg::QUEUE_DEPTH - 1)) ? '0 :
					rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

### design/ird_divider.sv
// Restoring divider, one quotient bit per cycle, on unsigned magnitudes.
// Uses ird_pkg::ACC_W and ird_pkg::div_result_t.
module ird_divider #(
	parameter int DIVISOR_W = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [ird_pkg::ACC_W-1:0]   dividend,
	input  logic [DIVISOR_W-1:0]        divisor,
	output ird_pkg::div_result_t        result
);

	localparam int CNT_W = $clog2(ird_pkg::ACC_W);

	logic                      busy_q;
	logic                      done_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [DIVISOR_W-1:0]      rem_q;
	logic [DIVISOR_W-1:0]      div_q;
	logic [ird_pkg::ACC_W-1:0] quo_q;
	logic [DIVISOR_W:0]        trial;
	logic [DIVISOR_W:0]        diff;
	logic                      fits;

	// remainder stays below the divisor, so the shifted trial needs one extra bit
	assign trial = {rem_q, quo_q[ird_pkg::ACC_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign fits  = (trial >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(ird_pkg::ACC_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
			quo_q <= {quo_q[ird_pkg::ACC_W-2:0], fits};
		end
	end

	assign result.done     = done_q;
	assign result.quotient = quo_q;

endmodule

### design/ird_back.sv
// Execution side: stores, multiply-accumulate over the record, divide, output register.
// Depends on ird_pkg and ird_divider.
module ird_back #(
	parameter int DEPTH        = 256,
	parameter int SAMPLE_WIDTH = 16,
	parameter int FRAC_BITS    = 12
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    q_valid,
	output logic                                    q_ready,
	input  logic [2*SAMPLE_WIDTH+$clog2(DEPTH)-1:0] q_data,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [ird_pkg::RESP_W-1:0]              response_sample,
	output logic [ird_pkg::INDEX_W-1:0]             sample_index,
	output ird_pkg::result_flags_t                  flags
);

	localparam int ADDR_W = $clog2(DEPTH);
	localparam int SW     = SAMPLE_WIDTH;
	localparam int RW     = ird_pkg::RESP_W;
	localparam int AW     = ird_pkg::ACC_W;
	localparam int PROD_W = SW + RW;

	ird_pkg::back_state_t state_q, state_d;

	// stores
	logic [SW-1:0] ctl_mem [DEPTH];
	logic [RW-1:0] rsp_mem [DEPTH];

	// item fields
	logic signed [SW-1:0] item_u;
	logic signed [SW-1:0] item_y;
	logic [ADDR_W-1:0]    item_k;

	// control strobes
	logic pop, issue, div_start, finish;

	// datapath registers
	logic signed [SW-1:0]     first_q;
	logic signed [SW-1:0]     y_q;
	logic [ADDR_W-1:0]        k_q;
	logic [ADDR_W-1:0]        i_q;
	logic signed [AW-1:0]     acc_q;
	logic signed [AW-1:0]     num_q;
	logic signed [RW-1:0]     g_q;
	logic                     clip_q;
	logic                     derr_q;
	logic                     neg_q;
	logic                     vld_s1, vld_s2;
	logic signed [SW-1:0]     ctl_s1;
	logic signed [RW-1:0]     rsp_s1;
	logic signed [PROD_W-1:0] prod_s2;

	// output register
	logic                         out_vld_q;
	logic [RW-1:0]                out_resp_q;
	logic [ird_pkg::INDEX_W-1:0]  out_idx_q;
	ird_pkg::result_flags_t       out_flags_q;

	// arithmetic
	logic signed [AW:0]   acc_sum;
	logic signed [AW-1:0] acc_next;
	logic                 acc_ovf;
	logic signed [AW-1:0] y_scaled;
	logic signed [AW:0]   num_sum;
	logic signed [AW-1:0] num_next;
	logic                 num_ovf;
	logic [AW-1:0]        dividend_mag;
	logic [SW-1:0]        divisor_mag;
	logic [AW-1:0]        quo_mag;
	logic signed [RW-1:0] quo_clamped;
	logic                 quo_clip;
	ird_pkg::div_result_t div_res;

	assign item_u = q_data[SW-1:0];
	assign item_y = q_data[2*SW-1:SW];
	assign item_k = q_data[2*SW +: ADDR_W];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ird_pkg::ST_IDLE: begin
				if (q_valid) begin
					if ((item_k == '0) || (first_q == '0)) begin
						state_d = ird_pkg::ST_DONE;
					end else if (item_k == ADDR_W'(1)) begin
						state_d = ird_pkg::ST_DIFF;
					end else begin
						state_d = ird_pkg::ST_MAC;
					end
				end
			end
			ird_pkg::ST_MAC: begin
				if (i_q == (k_q - ADDR_W'(1))) begin
					state_d = ird_pkg::ST_DRAIN;
				end
			end
			ird_pkg::ST_DRAIN: begin
				if (!vld_s1 && !vld_s2) begin
					state_d = ird_pkg::ST_DIFF;
				end
			end
			ird_pkg::ST_DIFF:   state_d = ird_pkg::ST_DIV_GO;
			ird_pkg::ST_DIV_GO: state_d = ird_pkg::ST_DIV_WAIT;
			ird_pkg::ST_DIV_WAIT: begin
				if (div_res.done) begin
					state_d = ird_pkg::ST_QUOT;
				end
			end
			ird_pkg::ST_QUOT: state_d = ird_pkg::ST_DONE;
			ird_pkg::ST_DONE: begin
				if (!out_vld_q || out_ready) begin
					state_d = ird_pkg::ST_IDLE;
				end
			end
			default: state_d = ird_pkg::ST_IDLE;
		endcase
	end

	// strobes
	always_comb begin
		q_ready   = (state_q == ird_pkg::ST_IDLE);
		pop       = q_ready & q_valid;
		issue     = (state_q == ird_pkg::ST_MAC);
		div_start = (state_q == ird_pkg::ST_DIV_GO);
		finish    = (state_q == ird_pkg::ST_DONE) && (!out_vld_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ird_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// saturating accumulate of one product
	assign acc_sum  = (AW+1)'(acc_q) + (AW+1)'(prod_s2);
	assign acc_ovf  = (acc_sum[AW] != acc_sum[AW-1]);
	assign acc_next = acc_ovf ? (acc_sum[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}})
		: acc_sum[AW-1:0];

	// saturating numerator y * 2^FRAC_BITS - acc
	assign y_scaled = AW'(y_q) <<< FRAC_BITS;
	assign num_sum  = (AW+1)'(y_scaled) - (AW+1)'(acc_q);
	assign num_ovf  = (num_sum[AW] != num_sum[AW-1]);
	assign num_next = num_ovf ? (num_sum[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}})
		: num_sum[AW-1:0];

	// magnitudes for the unsigned divider
	assign dividend_mag = num_q[AW-1] ? (AW'(0) - num_q) : num_q;
	assign divisor_mag  = first_q[SW-1] ? (SW'(0) - first_q) : first_q;

	// sign and clip the quotient to 32 bits
	assign quo_mag = div_res.quotient;
	always_comb begin
		quo_clip    = 1'b0;
		quo_clamped = quo_mag[RW-1:0];
		if (neg_q) begin
			if (quo_mag > {{(AW-RW){1'b0}}, 1'b1, {(RW-1){1'b0}}}) begin
				quo_clip    = 1'b1;
				quo_clamped = {1'b1, {(RW-1){1'b0}}};
			end else begin
				quo_clamped = RW'(0) - quo_mag[RW-1:0];
			end
		end else if (quo_mag > {{(AW-RW+1){1'b0}}, {(RW-1){1'b1}}}) begin
			quo_clip    = 1'b1;
			quo_clamped = {1'b0, {(RW-1){1'b1}}};
		end
	end

	ird_divider #(
		.DIVISOR_W(SW)
	) u_divider (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(dividend_mag),
		.divisor (divisor_mag),
		.result  (div_res)
	);

	// stores: control written as an item enters, response as it leaves
	always_ff @(posedge clk) begin
		if (pop) begin
			ctl_mem[item_k] <= item_u;
		end
		if (finish) begin
			rsp_mem[k_q] <= g_q;
		end
		ctl_s1 <= ctl_mem[i_q];
		rsp_s1 <= rsp_mem[k_q - i_q];
	end

	// multiply stage
	always_ff @(posedge clk) begin
		prod_s2 <= PROD_W'(ctl_s1) * PROD_W'(rsp_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			first_q <= '0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
			if (pop && (item_k == '0)) begin
				first_q <= item_u;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			y_q    <= item_y;
			k_q    <= item_k;
			i_q    <= ADDR_W'(1);
			acc_q  <= '0;
			clip_q <= 1'b0;
			derr_q <= 1'b0;
			if (item_k == '0) begin
				g_q <= RW'(item_y);
			end else if (first_q == '0) begin
				g_q    <= '0;
				derr_q <= 1'b1;
			end
		end else begin
			if (issue) begin
				i_q <= i_q + ADDR_W'(1);
			end
			if (vld_s2) begin
				acc_q <= acc_next;
				if (acc_ovf) begin
					clip_q <= 1'b1;
				end
			end
			if (state_q == ird_pkg::ST_DIFF) begin
				num_q <= num_next;
				if (num_ovf) begin
					clip_q <= 1'b1;
				end
			end
			if (div_start) begin
				neg_q <= num_q[AW-1] ^ first_q[SW-1];
			end
			if (state_q == ird_pkg::ST_QUOT) begin
				g_q <= quo_clamped;
				if (quo_clip) begin
					clip_q <= 1'b1;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (finish) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_resp_q               <= g_q;
			out_idx_q                <= ird_pkg::INDEX_W'(k_q);
			out_flags_q.saturated    <= clip_q;
			out_flags_q.divide_error <= derr_q;
		end
	end

	assign out_valid       = out_vld_q;
	assign response_sample = out_resp_q;
	assign sample_index    = out_idx_q;
	assign flags           = out_flags_q;

endmodule

### design/impulse_response_deconvolution.sv
// Top level of the impulse response deconvolution block.
// Depends on ird_pkg, ird_front, ird_queue and ird_back.
//
// Slave channel s_*: one transfer per sample pair, u_k in the low SAMPLE_WIDTH
// bits of s_tdata and y_k above it; s_tuser marks the first pair of a record.
// After reset the first transfer always opens a record, and a record that
// reaches DEPTH pairs wraps to a new one.
// Master channel m_*: one transfer per input transfer, in order, carrying the
// response sample g_k, its index k and two status flags.
// Items are worked one at a time. An item with k = 0, or with a zero first
// control sample, goes straight to the finish step; any other runs k - 1 serial
// multiply-accumulates (none at k = 1), a drain of the multiply pipeline (stages
// s1 and s2) and a 64-step bit-serial divide by u_0.
// A two-entry queue lets the front accept pairs while the back computes, and
// the output register lets the back take its next item while a result waits.
// When the receiver stalls, hold the result on m_* and stop the back at its
// finish step; the queue then fills and s_tready drops.
// Reset clears control state only; the sample stores need no clearing.
module impulse_response_deconvolution #(
	parameter int DEPTH        = 256,
	parameter int SAMPLE_WIDTH = 16,
	parameter int FRAC_BITS    = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [SW-1:0] control_sample, [2SW-1:SW] output_sample, zero padding above
	input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
	// [0] record_start
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [31:0] response_sample, [39:32] sample_index
	output logic [39:0]                         m_tdata,
	// [0] saturated, [1] divide_error
	output logic [1:0]                          m_tuser
);

	localparam int ADDR_W = $clog2(DEPTH);
	localparam int ITEM_W = 2*SAMPLE_WIDTH + ADDR_W;

	// front to queue
	logic              push_valid;
	logic              push_ready;
	logic [ITEM_W-1:0] push_data;

	// queue to back
	logic              pop_valid;
	logic              pop_ready;
	logic [ITEM_W-1:0] pop_data;

	// result payload
	logic [ird_pkg::RESP_W-1:0]  response_sample;
	logic [ird_pkg::INDEX_W-1:0] sample_index;
	ird_pkg::result_flags_t      flags;

	// number each pair within its record
	ird_front #(
		.DEPTH       (DEPTH),
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data)
	);

	// decouple intake from the long per-item computation
	ird_queue #(
		.WIDTH(ITEM_W)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(push_valid),
		.wr_ready(push_ready),
		.wr_data (push_data),
		.rd_valid(pop_valid),
		.rd_ready(pop_ready),
		.rd_data (pop_data)
	);

	// forward substitution, divide and output register
	ird_back #(
		.DEPTH       (DEPTH),
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (pop_valid),
		.q_ready        (pop_ready),
		.q_data         (pop_data),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.response_sample(response_sample),
		.sample_index   (sample_index),
		.flags          (flags)
	);

	// pack the result, response sample lowest
	assign m_tdata = {sample_index, response_sample};
	assign m_tuser = flags;

endmodule
